[sv/ppd_pkg.sv]
// Shared constants and types of the preemptive priority dispatcher.
// No dependencies; imported by the dispatcher top level.
package ppd_pkg;

  localparam int unsigned ReadyDepth = 64;
  localparam int unsigned MaxCpus    = 8;
  localparam int unsigned SlotW      = $clog2(ReadyDepth);
  localparam int unsigned CpuW       = $clog2(MaxCpus);
  localparam logic [23:0] MinRemainMs = 24'd10;

  typedef enum logic [1:0] {
    ACT_DISPATCH = 2'd0,
    ACT_PREEMPT  = 2'd1,
    ACT_NONE     = 2'd2,
    ACT_DROPPED  = 2'd3
  } action_e;

  typedef struct packed {
    logic [7:0]  job;
    logic [7:0]  prio;
    logic [23:0] rem;
  } entry_t;

  typedef struct packed {
    logic        vld;
    action_e     act;
    logic [2:0]  cpu;
    logic [7:0]  job;
    logic [23:0] rem;
  } res_t;

endpackage

[sv/preemptive_priority_dispatcher.sv]
// Preemptive priority dispatcher: ready table in a synchronous memory and a
// sequencer that preempts, scans for the best job and dispatches.
// Depends on ppd_pkg.
//
// Steps: when every active processor is busy, a new job first preempts them,
// then busy processors are passed over and each free one is filled in turn
// (select, a scan of the whole table one entry a cycle through the memory
// read port plus a drain, dispatch) while the table holds jobs.
// One item at a time: busy is high from acceptance until the sequencer goes
// idle, and the final result, with last_o set, is strobed as busy falls.
// Results are strobed one cycle each and the receiver cannot stall them.
// Reset empties the table, frees all processors and sets active_cpus to 8.
module preemptive_priority_dispatcher import ppd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [7:0]  job_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [23:0] remaining_ms_i,
  input  logic [2:0]  cpu_index_i,
  input  logic [31:0] now_ms_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  action_o,
  output logic [2:0]  cpu_o,
  output logic [7:0]  job_out_o,
  output logic [23:0] remaining_out_o,
  output logic        last_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PRE  = 6'b000010,
    ST_SEL  = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_DISP = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // The configuration register is writable only while no item is in flight
  // and none is being handed over.
  logic [3:0] active_q;
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 4'(MaxCpus);
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_data_i;
    end
  end

  // Clamp the register to the usable range 1..MaxCpus.
  logic [CpuW:0] act_n;
  always_comb begin
    if (active_q == 4'd0) begin
      act_n = (CpuW+1)'(1);
    end else if (active_q > 4'(MaxCpus)) begin
      act_n = (CpuW+1)'(MaxCpus);
    end else begin
      act_n = (CpuW+1)'(active_q);
    end
  end

  logic [MaxCpus-1:0] act_mask;
  always_comb begin
    for (int i = 0; i < MaxCpus; i++) begin
      act_mask[i] = ((CpuW+1)'(i) < act_n);
    end
  end

  // Ready table: valid bits in flip-flops, payload in a memory.
  logic [ReadyDepth-1:0] rv_q;
  entry_t                mem [ReadyDepth];
  entry_t                rd_data_q;
  logic                  we;
  logic [SlotW-1:0]      wa;
  entry_t                wd;

  // Processor table, one entry per processor.
  logic [MaxCpus-1:0] busy_q;
  logic [7:0]         run_job_q   [MaxCpus];
  logic [7:0]         run_prio_q  [MaxCpus];
  logic [23:0]        run_rem_q   [MaxCpus];
  logic [31:0]        run_start_q [MaxCpus];

  logic [CpuW:0]  cpu_q;
  logic [CpuW-1:0] c_idx;
  logic [31:0]    now_q;
  logic [SlotW:0] cnt_q;
  logic           p_vld_q;
  logic [SlotW-1:0] p_slot_q;
  logic           best_fnd_q;
  logic [SlotW-1:0] best_slot_q;
  logic [7:0]     best_prio_q;
  logic [7:0]     best_job_q;
  logic [23:0]    best_rem_q;
  res_t           pend_q;
  res_t           res_new;
  logic           fin;

  assign c_idx = cpu_q[CpuW-1:0];
  assign busy  = (state_q != ST_IDLE);

  // First free table slot.
  logic             free_any;
  logic [SlotW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int s = ReadyDepth - 1; s >= 0; s--) begin
      if (!rv_q[s]) begin
        free_any = 1'b1;
        free_idx = SlotW'(s);
      end
    end
  end

  // Remaining time of a preempted job, floored at the minimum.
  logic [31:0] elapsed;
  logic [31:0] rem_ext;
  logic [31:0] rem_diff;
  logic [23:0] rem_pre;
  assign elapsed  = now_q - run_start_q[c_idx];
  assign rem_ext  = {8'd0, run_rem_q[c_idx]};
  assign rem_diff = rem_ext - elapsed;
  always_comb begin
    if (elapsed >= rem_ext || rem_diff < {8'd0, MinRemainMs}) begin
      rem_pre = MinRemainMs;
    end else begin
      rem_pre = rem_diff[23:0];
    end
  end

  logic accept;
  assign accept = start && !busy;

  // Sequencer: next state, memory write and the result produced this cycle.
  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    wa      = free_idx;
    wd      = '0;
    res_new = '0;
    fin     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!req_type_i) begin
            if (free_any) begin
              we = 1'b1;
              wd = '{job: job_id_i, prio: priority_req_i, rem: remaining_ms_i};
              // With every active processor busy, each of them is preempted while the table has a free slot.
              state_d = ((~busy_q & act_mask) == '0) ? ST_PRE : ST_SEL;
            end else begin
              res_new = '{vld: 1'b1, act: ACT_DROPPED, cpu: 3'd0,
                          job: job_id_i, rem: remaining_ms_i};
              state_d = ST_SEL;
            end
          end else begin
            state_d = ST_SEL;
          end
        end
      end
      ST_PRE: begin
        if (cpu_q >= act_n) begin
          state_d = ST_SEL;
        end else if (busy_q[c_idx] && free_any) begin
          we = 1'b1;
          wd = '{job: run_job_q[c_idx], prio: run_prio_q[c_idx], rem: rem_pre};
          res_new = '{vld: 1'b1, act: ACT_PREEMPT, cpu: 3'(c_idx),
                      job: run_job_q[c_idx], rem: rem_pre};
        end
      end
      ST_SEL: begin
        if (cpu_q >= act_n || rv_q == '0) begin
          state_d = ST_FIN;
        end else if (!busy_q[c_idx]) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == (SlotW+1)'(ReadyDepth)) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        res_new = '{vld: 1'b1, act: ACT_DISPATCH, cpu: 3'(c_idx),
                    job: best_job_q, rem: best_rem_q};
        state_d = ST_SEL;
      end
      ST_FIN: begin
        fin     = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory: one write port, one registered read port driven by the scan.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[cnt_q[SlotW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rv_q       <= '0;
      busy_q     <= '0;
      cpu_q      <= '0;
      cnt_q      <= '0;
      p_vld_q    <= 1'b0;
      best_fnd_q <= 1'b0;
      pend_q     <= '0;
    end else begin
      state_q <= state_d;
      if (we) begin
        rv_q[wa] <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          cpu_q <= '0;
          if (accept && req_type_i) begin
            busy_q[cpu_index_i] <= 1'b0;
          end
        end
        ST_PRE: begin
          if (cpu_q >= act_n) begin
            cpu_q <= '0;
          end else begin
            if (busy_q[c_idx] && free_any) begin
              busy_q[c_idx] <= 1'b0;
            end
            cpu_q <= cpu_q + 1'b1;
          end
        end
        ST_SEL: begin
          cnt_q      <= '0;
          p_vld_q    <= 1'b0;
          best_fnd_q <= 1'b0;
          if (cpu_q < act_n && rv_q != '0 && busy_q[c_idx]) begin
            cpu_q <= cpu_q + 1'b1;
          end
        end
        ST_SCAN: begin
          if (p_vld_q && rv_q[p_slot_q] &&
              (!best_fnd_q || rd_data_q.prio > best_prio_q)) begin
            best_fnd_q <= 1'b1;
          end
          if (cnt_q != (SlotW+1)'(ReadyDepth)) begin
            p_vld_q <= 1'b1;
            cnt_q   <= cnt_q + 1'b1;
          end else begin
            p_vld_q <= 1'b0;
          end
        end
        ST_DISP: begin
          rv_q[best_slot_q] <= 1'b0;
          busy_q[c_idx]     <= 1'b1;
          cpu_q             <= cpu_q + 1'b1;
        end
        default: ;
      endcase
      // Hold one result back so that the final one can carry last_o.
      if (res_new.vld) begin
        pend_q <= res_new;
      end else if (fin) begin
        pend_q <= '0;
      end
    end
  end

  // Payload registers: scan pipeline, best candidate and processor entries.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= now_ms_i;
    end
    p_slot_q <= cnt_q[SlotW-1:0];
    if (state_q == ST_SCAN && p_vld_q && rv_q[p_slot_q] &&
        (!best_fnd_q || rd_data_q.prio > best_prio_q)) begin
      best_slot_q <= p_slot_q;
      best_prio_q <= rd_data_q.prio;
      best_job_q  <= rd_data_q.job;
      best_rem_q  <= rd_data_q.rem;
    end
    if (state_q == ST_DISP) begin
      run_job_q[c_idx]   <= best_job_q;
      run_prio_q[c_idx]  <= best_prio_q;
      run_rem_q[c_idx]   <= best_rem_q;
      run_start_q[c_idx] <= now_q;
    end
  end

  // Result strobe register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o  <= 1'b0;
      action_o        <= 2'(ACT_NONE);
      cpu_o           <= '0;
      job_out_o       <= '0;
      remaining_out_o <= '0;
      last_o          <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      last_o         <= 1'b0;
      if (res_new.vld && pend_q.vld) begin
        result_valid_o  <= 1'b1;
        action_o        <= 2'(pend_q.act);
        cpu_o           <= pend_q.cpu;
        job_out_o       <= pend_q.job;
        remaining_out_o <= pend_q.rem;
      end else if (fin) begin
        result_valid_o <= 1'b1;
        last_o         <= 1'b1;
        if (pend_q.vld) begin
          action_o        <= 2'(pend_q.act);
          cpu_o           <= pend_q.cpu;
          job_out_o       <= pend_q.job;
          remaining_out_o <= pend_q.rem;
        end else begin
          action_o        <= 2'(ACT_NONE);
          cpu_o           <= '0;
          job_out_o       <= '0;
          remaining_out_o <= '0;
        end
      end
    end
  end

  // An item's held result is always flushed before the sequencer goes idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_q.vld)
    else $error("held result left behind while idle");

  // The final result of an item appears exactly as the sequencer goes idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> state_q == ST_IDLE)
    else $error("last result while still busy");

  // A dispatch always has a candidate found by the scan and goes to a free processor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DISP |-> best_fnd_q && !busy_q[c_idx])
    else $error("dispatch without candidate or onto a busy processor");

  // An accepted item always makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not start the sequencer");

endmodule

[test/preemptive_priority_dispatcher_tb.sv]
// Self-checking testbench of the preemptive priority dispatcher: directed table, a full-table run, then random items.
// Depends on ppd_pkg and the preemptive_priority_dispatcher top level.
module preemptive_priority_dispatcher_tb;
  import ppd_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic [1:0]  act;
    logic [2:0]  cpu;
    logic [7:0]  job;
    logic [23:0] rem;
    logic        last;
  } outcome_t;

  // One row of the directed table; where chk is set, the first result is also typed in.
  typedef struct {
    logic        is_cfg;
    logic [3:0]  cfg;
    logic        kind;
    logic [7:0]  job;
    logic [7:0]  prio;
    logic [23:0] rem;
    logic [2:0]  cidx;
    logic [31:0] now;
    logic        chk;
    outcome_t    first;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type_i = 1'b0;
  logic [7:0]  job_id_i = '0;
  logic [7:0]  priority_req_i = '0;
  logic [23:0] remaining_ms_i = '0;
  logic [2:0]  cpu_index_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;
  logic        result_valid_o;
  logic [1:0]  action_o;
  logic [2:0]  cpu_o;
  logic [7:0]  job_out_o;
  logic [23:0] remaining_out_o;
  logic        last_o;

  preemptive_priority_dispatcher uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow state of the dispatcher.
  logic        tbl_vld [ReadyDepth];
  logic [7:0]  tbl_job [ReadyDepth];
  logic [7:0]  tbl_prio [ReadyDepth];
  logic [23:0] tbl_rem [ReadyDepth];
  logic        run_busy [MaxCpus];
  logic [7:0]  run_job [MaxCpus];
  logic [7:0]  run_prio [MaxCpus];
  logic [23:0] run_rem [MaxCpus];
  logic [31:0] run_start [MaxCpus];
  logic [3:0]  cpus_reg;

  outcome_t pending_actions[$];
  int errors = 0;
  int items_done = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  logic [31:0] clock_ms = 0;

  function automatic int first_free_slot();
    for (int s = 0; s < ReadyDepth; s++) if (!tbl_vld[s]) return s;
    return -1;
  endfunction

  function automatic void add_action(logic [1:0] a, logic [2:0] c, logic [7:0] j,
                                     logic [23:0] r, ref int n);
    outcome_t o;
    o = '{act: a, cpu: c, job: j, rem: r, last: 1'b0};
    pending_actions.push_back(o);
    n++;
  endfunction

  // Applies one item to the shadow state and queues the actions it should cause.
  function automatic void schedule_item(logic kind, logic [7:0] jid, logic [7:0] pr,
                                        logic [23:0] rms, logic [2:0] ci, logic [31:0] now);
    int n, used, s, t, best;
    logic any_free;
    logic [31:0] el, r;
    n = 0;
    used = (cpus_reg == 0) ? 1 : (cpus_reg > MaxCpus) ? MaxCpus : cpus_reg;
    if (kind == 1'b0) begin
      s = first_free_slot();
      if (s < 0) begin
        add_action(ACT_DROPPED, 3'd0, jid, rms, n);
      end else begin
        tbl_vld[s] = 1'b1; tbl_job[s] = jid; tbl_prio[s] = pr; tbl_rem[s] = rms;
        any_free = 1'b0;
        for (int c = 0; c < used; c++) if (!run_busy[c]) any_free = 1'b1;
        if (!any_free) begin
          for (int c = 0; c < used; c++) begin
            if (!run_busy[c]) continue;
            t = first_free_slot();
            if (t < 0) continue;
            el = now - run_start[c];
            r = {8'd0, run_rem[c]};
            // Elapsed time at or beyond the remaining time, or a remainder under the floor.
            if (el >= r || r - el < 32'(MinRemainMs)) r = 32'(MinRemainMs);
            else r = r - el;
            run_busy[c] = 1'b0;
            tbl_vld[t] = 1'b1; tbl_job[t] = run_job[c];
            tbl_prio[t] = run_prio[c]; tbl_rem[t] = r[23:0];
            add_action(ACT_PREEMPT, 3'(c), run_job[c], r[23:0], n);
          end
        end
      end
    end else begin
      run_busy[ci] = 1'b0;
    end
    for (int c = 0; c < used; c++) begin
      if (run_busy[c]) continue;
      best = -1;
      for (int q = 0; q < ReadyDepth; q++)
        if (tbl_vld[q] && (best < 0 || tbl_prio[q] > tbl_prio[best])) best = q;
      if (best < 0) break;
      tbl_vld[best] = 1'b0;
      run_busy[c] = 1'b1; run_job[c] = tbl_job[best]; run_prio[c] = tbl_prio[best];
      run_rem[c] = tbl_rem[best]; run_start[c] = now;
      add_action(ACT_DISPATCH, 3'(c), run_job[c], run_rem[c], n);
    end
    if (n == 0) add_action(ACT_NONE, 3'd0, 8'd0, 24'd0, n);
    pending_actions[$].last = 1'b1;
  endfunction

  function automatic void report_mismatch(string what, outcome_t exp_o, outcome_t got);
    errors++;
    if (errors <= 10)
      $display("Mismatch (%s): expected act=%0d cpu=%0d job=%0d rem=%0d last=%0d, got act=%0d cpu=%0d job=%0d rem=%0d last=%0d",
               what, exp_o.act, exp_o.cpu, exp_o.job, exp_o.rem, exp_o.last,
               got.act, got.cpu, got.job, got.rem, got.last);
  endfunction

  // Result monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t got;
    if (rst_ni && result_valid_o) begin
      got = '{act: action_o, cpu: cpu_o, job: job_out_o, rem: remaining_out_o, last: last_o};
      results_seen++;
      if (pending_actions.size() == 0) report_mismatch("unexpected", '0, got);
      else if (pending_actions[0] !== got) report_mismatch("field", pending_actions.pop_front(), got);
      else void'(pending_actions.pop_front());
    end
  end

  // Watchdog: too many cycles in a row with no item accepted, no result and no configuration write ends the run.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_active_cpus(logic [3:0] v);
    // Let the block settle before the register changes.
    wait (pending_actions.size() == 0);
    repeat (600) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cpus_reg = v;
  endtask

  // Hands one item over and predicts it at the edge that accepts it.
  task automatic send_item(logic kind, logic [7:0] jid, logic [7:0] pr, logic [23:0] rms,
                           logic [2:0] ci, logic [31:0] now);
    int gap;
    gap = ($urandom_range(99) < send_gap) ? $urandom_range(1, 6) : 0;
    repeat (gap) @(posedge clk_i);
    start <= 1'b1;
    req_type_i <= kind; job_id_i <= jid; priority_req_i <= pr;
    remaining_ms_i <= rms; cpu_index_i <= ci; now_ms_i <= now;
    do @(posedge clk_i); while (busy);
    schedule_item(kind, jid, pr, rms, ci, now);
    items_done++;
    start <= 1'b0;
    // Wait for the final result so that the next start never overlaps this one.
    wait (pending_actions.size() == 0);
  endtask

  // A directed row: the typed-in first result, where given, must agree with the prediction.
  task automatic send_item_checked(row_t r, output outcome_t head);
    int before_n;
    before_n = pending_actions.size();
    start <= 1'b1;
    req_type_i <= r.kind; job_id_i <= r.job; priority_req_i <= r.prio;
    remaining_ms_i <= r.rem; cpu_index_i <= r.cidx; now_ms_i <= r.now;
    do @(posedge clk_i); while (busy);
    schedule_item(r.kind, r.job, r.prio, r.rem, r.cidx, r.now);
    items_done++;
    start <= 1'b0;
    head = pending_actions[before_n];
    if (r.chk && head !== r.first) report_mismatch("directed", r.first, head);
    wait (pending_actions.size() == 0);
  endtask

  task automatic random_phase(int count);
    logic [31:0] now;
    for (int i = 0; i < count; i++) begin
      clock_ms = clock_ms + $urandom_range(0, 3000);
      now = ($urandom_range(19) == 0) ? $urandom : clock_ms;
      if ($urandom_range(2) == 0)
        send_item(1'b1, 8'($urandom), 8'($urandom), 24'($urandom), 3'($urandom), now);
      else
        send_item(1'b0, 8'($urandom), ($urandom_range(3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom),
                  ($urandom_range(4) == 0) ? 24'($urandom_range(0, 40)) : 24'($urandom),
                  3'($urandom), now);
    end
  endtask

  row_t directed[$];

  initial begin
    outcome_t d0;
    for (int s = 0; s < ReadyDepth; s++) tbl_vld[s] = 1'b0;
    for (int c = 0; c < MaxCpus; c++) run_busy[c] = 1'b0;
    cpus_reg = 4'(MaxCpus);

    // Directed rows: nothing to do after reset, extremes, preemption and the floor.
    directed.push_back('{0, 0, 1, 0, 0, 0, 3'd0, 0, 1, '{ACT_NONE, 3'd0, 8'd0, 24'd0, 1'b1}});
    directed.push_back('{0, 0, 0, 8'hFF, 8'hFF, 24'hFFFFFF, 3'd7, 32'hFFFFFFFF, 1,
                         '{ACT_DISPATCH, 3'd0, 8'hFF, 24'hFFFFFF, 1'b1}});
    directed.push_back('{0, 0, 1, 0, 0, 0, 3'd5, 0, 1, '{ACT_NONE, 3'd0, 8'd0, 24'd0, 1'b1}});
    directed.push_back('{1, 4'd1, 0, 0, 0, 0, 0, 0, 0, '0});
    directed.push_back('{0, 0, 0, 8'd1, 8'd0, 24'd0, 3'd0, 32'd5, 0, '0});
    directed.push_back('{0, 0, 0, 8'd2, 8'd200, 24'd50, 3'd0, 32'd20, 0, '0});
    directed.push_back('{0, 0, 0, 8'd3, 8'd200, 24'd5, 3'd0, 32'd30, 0, '0});
    directed.push_back('{0, 0, 1, 0, 0, 0, 3'd0, 32'd40, 0, '0});
    directed.push_back('{0, 0, 1, 0, 0, 0, 3'd7, 32'd50, 0, '0});
    directed.push_back('{1, 4'd0, 0, 0, 0, 0, 0, 0, 0, '0});
    directed.push_back('{0, 0, 0, 8'd4, 8'd9, 24'd1000, 3'd0, 32'd100, 0, '0});
    directed.push_back('{1, 4'd15, 0, 0, 0, 0, 0, 0, 0, '0});
    directed.push_back('{0, 0, 0, 8'd5, 8'd9, 24'd700, 3'd0, 32'd150, 0, '0});
    directed.push_back('{1, 4'd8, 0, 0, 0, 0, 0, 0, 0, '0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_active_cpus(directed[i].cfg);
      end else begin
        send_item_checked(directed[i], d0);
      end
    end

    // Fill the table to its end with two processors, so that arrivals are dropped.
    write_active_cpus(4'd2);
    for (int i = 0; i < ReadyDepth + 4; i++)
      send_item(1'b0, 8'(i), 8'($urandom), 24'($urandom_range(0, 100)), 3'd0, clock_ms);
    for (int i = 0; i < 8; i++) send_item(1'b1, 0, 0, 0, 3'(i), clock_ms);

    send_gap = 18;
    random_phase(40);
    write_active_cpus(4'd3);
    send_gap = 51;
    random_phase(40);
    write_active_cpus(4'd8);
    send_gap = 0;
    random_phase(40);

    wait (pending_actions.size() == 0);
    repeat (600) @(posedge clk_i);
    $display("Covered %0d items and %0d results over several processor counts,", items_done,
             results_seen);
    $display("including a full table, preemption with the time floor and ignored completions.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
